### hw/rtl/rsnh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsnh_pkg
// Shared types, constants and helper functions of the ray / segment
// nearest-hit block.
// ----------------------------------------------------------------------------
package rsnh_pkg;

  localparam int MAX_SEGMENTS = 1024;
  localparam int SEG_ADDR_W   = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W    = SEG_ADDR_W + 1;
  localparam int COORD_W      = 32;
  localparam int FRAC_BITS    = 24;

  // Register indexes of the configuration port.
  localparam logic CFG_SEGMENT_COUNT = 1'b0;
  localparam logic CFG_RAY_OFFSET    = 1'b1;

  // Input commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } seg_t;

  // Request to the shared long divider. The partial remainder starts at
  // rem_init and the feed bits enter it one per step, most significant first.
  typedef struct packed {
    logic        start;
    logic [62:0] rem_init;
    logic [62:0] divisor;
    logic [30:0] feed;
    logic [4:0]  steps;
  } div_req_t;

  // Clamp to +-(2^31 - 1).
  function automatic logic signed [31:0] sat_lim(input logic signed [35:0] v);
    logic signed [35:0] hi;
    hi = 36'sd2147483647;
    if (v > hi) return 32'sd2147483647;
    if (v < -hi) return -32'sd2147483647;
    return v[31:0];
  endfunction

  // Clamp to the full signed coordinate range.
  function automatic logic signed [31:0] sat_coord(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rsnh_seg_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsnh_seg_mem
// Segment table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rsnh_seg_mem
  import rsnh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [SEG_ADDR_W-1:0] waddr,
  input  wire seg_t                  wdata,
  input  wire logic [SEG_ADDR_W-1:0] raddr,
  output seg_t                       rdata
);

  seg_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/rsnh_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsnh_div
// Restoring long divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsnh_div
  import rsnh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output logic          done,
  output logic [30:0]   quot
);

  logic [62:0] rem;
  logic [62:0] divisor;
  logic [30:0] feed;
  logic [4:0]  cnt;
  logic        running;
  logic [63:0] trial;

  assign trial = {rem, feed[30]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        rem     <= req.rem_init;
        divisor <= req.divisor;
        feed    <= req.feed;
        cnt     <= req.steps;
        quot    <= '0;
      end else if (running) begin
        feed <= {feed[29:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem  <= 63'(trial - {1'b0, divisor});
          quot <= {quot[29:0], 1'b1};
        end else begin
          rem  <= trial[62:0];
          quot <= {quot[29:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rsnh_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsnh_isqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rsnh_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] xr;
  logic [63:0] r;
  logic [63:0] bitv;
  logic        running;
  logic [63:0] cand;

  assign cand = r + bitv;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        xr      <= x;
        r       <= '0;
        bitv    <= 64'd1 << 62;
      end else if (running) begin
        if (xr >= cand) begin
          xr <= xr - cand;
          r  <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ray_segment_nearest_hit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit
// Nearest ray / segment intersection over a table of 2D segments.
// ----------------------------------------------------------------------------
// Usage. A command is taken on a rising edge with start high and busy low.
// A write command (cmd = 0) stores a segment in slot seg_index in that same
// cycle and produces no result; busy stays low, so writes go back to back.
// A query command (cmd = 1) raises busy and walks the segment table one slot
// at a time with a single memory read port, a shared 32x32 multiplier and a
// shared long divider. A segment that fails the candidate test is rejected
// early; otherwise its ray parameter is divided out. The winning segment's
// unit normal is computed once at the end (normalize, square root, two
// divisions); the normalize step shifts the edge vector up as far as it
// has to go before the square root is taken. The result
// transfer is a single-cycle done strobe with all result ports valid; the
// receiver cannot stall it, so it must take the transfer in that cycle.
// Configuration writes (cfg_we) take effect at once and must only be issued
// while busy is low. Reset (synchronous, active high) returns the sequencer
// to idle and sets segment_count to 0 and ray_offset to 168; the segment
// table is not cleared and slots must be written before a query reads them.
// ----------------------------------------------------------------------------
module ray_segment_nearest_hit
  import rsnh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd,
  input  wire logic [9:0]         seg_index,
  input  wire logic signed [31:0] seg_ax,
  input  wire logic signed [31:0] seg_ay,
  input  wire logic signed [31:0] seg_bx,
  input  wire logic signed [31:0] seg_by,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic [30:0]        max_dist,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    done,
  output logic signed [31:0]      hit_x,
  output logic signed [31:0]      hit_y,
  output logic signed [31:0]      normal_x,
  output logic signed [31:0]      normal_y,
  output logic                    hit_found,
  output logic [30:0]             hit_param
);

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_NUDX  = 5'd1;
  localparam logic [4:0] S_NUDY  = 5'd2;
  localparam logic [4:0] S_NUDY2 = 5'd3;
  localparam logic [4:0] S_RD    = 5'd4;
  localparam logic [4:0] S_UW    = 5'd5;
  localparam logic [4:0] S_M0    = 5'd6;
  localparam logic [4:0] S_M1    = 5'd7;
  localparam logic [4:0] S_M2    = 5'd8;
  localparam logic [4:0] S_M3    = 5'd9;
  localparam logic [4:0] S_M4    = 5'd10;
  localparam logic [4:0] S_M5    = 5'd11;
  localparam logic [4:0] S_M6    = 5'd12;
  localparam logic [4:0] S_TEST  = 5'd13;
  localparam logic [4:0] S_DIV   = 5'd14;
  localparam logic [4:0] S_HX    = 5'd15;
  localparam logic [4:0] S_HY    = 5'd16;
  localparam logic [4:0] S_HY2   = 5'd17;
  localparam logic [4:0] S_NRM   = 5'd18;
  localparam logic [4:0] S_SQ0   = 5'd19;
  localparam logic [4:0] S_SQ1   = 5'd20;
  localparam logic [4:0] S_SQ2   = 5'd21;
  localparam logic [4:0] S_SQRT  = 5'd22;
  localparam logic [4:0] S_NXS   = 5'd23;
  localparam logic [4:0] S_DNX   = 5'd24;
  localparam logic [4:0] S_NYS   = 5'd25;
  localparam logic [4:0] S_DNY   = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  localparam logic [SEG_CNT_W-1:0] SEG_MAX = SEG_CNT_W'(MAX_SEGMENTS);

  // Configuration registers.
  logic [SEG_CNT_W-1:0] segment_count;
  logic [15:0]          ray_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
      ray_offset    <= 16'd168;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEGMENT_COUNT: segment_count <= cfg_data[SEG_CNT_W-1:0];
        CFG_RAY_OFFSET:    ray_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [4:0] state;
  logic       accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Segment table.
  seg_t seg_wr;
  seg_t seg_rd;
  logic [SEG_CNT_W-1:0] idx;
  logic [SEG_CNT_W-1:0] n_seg;
  logic [SEG_CNT_W-1:0] idx_inc;

  assign seg_wr  = '{ax: seg_ax, ay: seg_ay, bx: seg_bx, by: seg_by};
  assign idx_inc = idx + SEG_CNT_W'(1);

  rsnh_seg_mem u_mem (
    .clk   (clk),
    .we    (accept && (cmd == CMD_WRITE)),
    .waddr (seg_index),
    .wdata (seg_wr),
    .raddr (idx[SEG_ADDR_W-1:0]),
    .rdata (seg_rd)
  );

  // Query context.
  logic signed [31:0] ox, oy, vx, vy, svx, svy;
  logic [30:0]        tm;
  logic signed [33:0] px, py;
  logic signed [31:0] ux, uy, wx, wy;
  logic signed [63:0] acc, d, sn, tn;
  logic               found;
  logic signed [31:0] bux, buy;
  logic signed [31:0] hx, hy;
  logic [31:0]        nax, nay;
  logic [31:0]        len;
  logic signed [31:0] nx, ny;

  // Shared multiplier: operands chosen by state, product registered.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_NUDX:  begin mul_a = signed'({16'd0, ray_offset}); mul_b = vx; end
      S_NUDY:  begin mul_a = signed'({16'd0, ray_offset}); mul_b = vy; end
      S_M0:    begin mul_a = svx; mul_b = uy; end
      S_M1:    begin mul_a = svy; mul_b = ux; end
      S_M2:    begin mul_a = svx; mul_b = wy; end
      S_M3:    begin mul_a = svy; mul_b = wx; end
      S_M4:    begin mul_a = ux;  mul_b = wy; end
      S_M5:    begin mul_a = uy;  mul_b = wx; end
      S_HX:    begin mul_a = signed'({1'b0, tm}); mul_b = vx; end
      S_HY:    begin mul_a = signed'({1'b0, tm}); mul_b = vy; end
      S_SQ0:   begin mul_a = signed'(nax); mul_b = signed'(nax); end
      S_SQ1:   begin mul_a = signed'(nay); mul_b = signed'(nay); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Candidate test: orient so that the denominator is positive, then check
  // t > 0, 0 <= s <= 1 and t below 128.0 before committing to a division.
  logic signed [63:0] dn, snn, tnn;
  logic               pass;

  always_comb begin
    dn  = d[63] ? -d  : d;
    snn = d[63] ? -sn : sn;
    tnn = d[63] ? -tn : tn;
    pass = (d != 64'sd0) && (tnn > 64'sd0) && !snn[63] && (snn <= dn) &&
           ({7'd0, tnn} < {dn, 7'd0});
  end

  // Shared divider and square root.
  div_req_t    dreq;
  logic        div_done;
  logic [30:0] quot;
  logic [55:0] num_x, num_y;
  logic        sq_start, sq_done;
  logic [31:0] root;

  assign num_x = {nay[30:0], 24'd0} + 56'(len >> 1);
  assign num_y = {nax[30:0], 24'd0} + 56'(len >> 1);

  always_comb begin
    dreq = '0;
    unique case (state)
      S_TEST: begin
        dreq.start    = pass;
        dreq.rem_init = 63'(tnn[62:7]);
        dreq.divisor  = dn[62:0];
        dreq.feed     = {tnn[6:0], 24'd0};
        dreq.steps    = 5'd31;
      end
      S_NXS: begin
        dreq.start    = 1'b1;
        dreq.rem_init = 63'(num_x[55:26]);
        dreq.divisor  = 63'(len);
        dreq.feed     = {num_x[25:0], 5'd0};
        dreq.steps    = 5'd26;
      end
      S_NYS: begin
        dreq.start    = 1'b1;
        dreq.rem_init = 63'(num_y[55:26]);
        dreq.divisor  = 63'(len);
        dreq.feed     = {num_y[25:0], 5'd0};
        dreq.steps    = 5'd26;
      end
      default: ;
    endcase
  end

  rsnh_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quot (quot)
  );

  assign sq_start = (state == S_SQ2);

  rsnh_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (64'(acc + prod)),
    .done  (sq_done),
    .root  (root)
  );

  // A zero-length winner cannot occur, but a zero length still yields zero.
  logic signed [31:0] qn;
  assign qn = (len == 32'd0) ? 32'sd0 : signed'({6'd0, quot[25:0]});

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd == CMD_QUERY)) begin
            ox    <= origin_x;
            oy    <= origin_y;
            vx    <= dir_x;
            vy    <= dir_y;
            svx   <= sat_lim(36'(dir_x));
            svy   <= sat_lim(36'(dir_y));
            tm    <= max_dist;
            found <= 1'b0;
            idx   <= '0;
            n_seg <= (segment_count > SEG_MAX) ? SEG_MAX : segment_count;
            state <= S_NUDX;
          end
        end
        S_NUDX: state <= S_NUDY;
        S_NUDY: begin
          px    <= 34'(ox) + 34'(prod >>> FRAC_BITS);
          state <= S_NUDY2;
        end
        S_NUDY2: begin
          py    <= 34'(oy) + 34'(prod >>> FRAC_BITS);
          state <= (n_seg == '0) ? S_HX : S_RD;
        end
        S_RD: state <= S_UW;
        S_UW: begin
          ux    <= sat_lim(36'(seg_rd.bx) - 36'(seg_rd.ax));
          uy    <= sat_lim(36'(seg_rd.by) - 36'(seg_rd.ay));
          wx    <= sat_lim(36'(px) - 36'(seg_rd.ax));
          wy    <= sat_lim(36'(py) - 36'(seg_rd.ay));
          state <= S_M0;
        end
        S_M0: state <= S_M1;
        S_M1: begin
          acc   <= prod;
          state <= S_M2;
        end
        S_M2: begin
          d     <= acc - prod;
          state <= S_M3;
        end
        S_M3: begin
          acc   <= prod;
          state <= S_M4;
        end
        S_M4: begin
          sn    <= acc - prod;
          state <= S_M5;
        end
        S_M5: begin
          acc   <= prod;
          state <= S_M6;
        end
        S_M6: begin
          tn    <= acc - prod;
          state <= S_TEST;
        end
        S_TEST: begin
          if (pass) begin
            state <= S_DIV;
          end else begin
            idx   <= idx_inc;
            state <= (idx_inc == n_seg) ? S_HX : S_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // Strict compare keeps the lower slot on a tie.
            if (quot < tm) begin
              tm    <= quot;
              found <= 1'b1;
              bux   <= ux;
              buy   <= uy;
            end
            idx   <= idx_inc;
            state <= (idx_inc == n_seg) ? S_HX : S_RD;
          end
        end
        S_HX: state <= S_HY;
        S_HY: begin
          hx    <= sat_coord(40'(ox) + 40'(prod >>> FRAC_BITS));
          state <= S_HY2;
        end
        S_HY2: begin
          hy    <= sat_coord(40'(oy) + 40'(prod >>> FRAC_BITS));
          nax   <= bux[31] ? 32'(-bux) : 32'(bux);
          nay   <= buy[31] ? 32'(-buy) : 32'(buy);
          state <= found ? S_NRM : S_OUT;
        end
        S_NRM: begin
          // Scale the edge vector up so the larger component reaches 2^29.
          if (((nax | nay) != 32'd0) && (nax < 32'h2000_0000) &&
              (nay < 32'h2000_0000)) begin
            nax <= nax << 1;
            nay <= nay << 1;
          end else begin
            state <= S_SQ0;
          end
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin
          acc   <= prod;
          state <= S_SQ2;
        end
        S_SQ2: state <= S_SQRT;
        S_SQRT: begin
          if (sq_done) begin
            len   <= root;
            state <= S_NXS;
          end
        end
        S_NXS: state <= S_DNX;
        S_DNX: begin
          if (div_done) begin
            nx    <= (buy > 32'sd0) ? -qn : qn;
            state <= S_NYS;
          end
        end
        S_NYS: state <= S_DNY;
        S_DNY: begin
          if (div_done) begin
            ny    <= (bux < 32'sd0) ? -qn : qn;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          hit_x     <= hx;
          hit_y     <= hy;
          normal_x  <= found ? nx : 32'sd0;
          normal_y  <= found ? ny : 32'sd0;
          hit_found <= found;
          hit_param <= tm;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### test/rsnh_checker.sv
// ----------------------------------------------------------------------------
// rsnh_checker
// Watches the command, configuration and result ports of the nearest-hit
// block. It keeps its own segment table and register copies, predicts the
// result of each accepted query and compares every result field.
// ----------------------------------------------------------------------------
module rsnh_checker
  import rsnh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cmd,
  input  logic [9:0]         seg_index,
  input  logic signed [31:0] seg_ax,
  input  logic signed [31:0] seg_ay,
  input  logic signed [31:0] seg_bx,
  input  logic signed [31:0] seg_by,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic [30:0]        max_dist,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               done,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic               hit_found,
  input  logic [30:0]        hit_param,
  output int                 fail_count,
  output int                 pending
);

  localparam longint LIM31 = 64'sd2147483647;

  typedef struct {
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic               found;
    logic [30:0]        param;
  } ray_result_t;

  ray_result_t hit_queue[$];
  seg_t        segment_table[MAX_SEGMENTS];
  logic [10:0] seg_count_r = 11'd0;
  logic [15:0] offset_r    = 16'd168;

  initial fail_count = 0;
  initial pending = 0;

  function automatic longint clamp31(input longint v);
    if (v > LIM31) return LIM31;
    if (v < -LIM31) return -LIM31;
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unit_comp(input longint unsigned mag, input logic neg,
                                       input longint unsigned len);
    longint unsigned qv;
    if (len == 0) return 0;
    qv = ((mag << FRAC_BITS) + (len >> 1)) / len;
    return neg ? -longint'(qv) : longint'(qv);
  endfunction

  // Nearest hit over the active part of the table. The ray parameter is
  // formed as an integer quotient followed by 24 fraction bits of long
  // division, so nothing overflows 64 bits.
  function automatic ray_result_t nearest_hit(input logic signed [31:0] ox, oy, vx, vy,
                                              input logic [30:0] limit);
    ray_result_t res;
    longint px, py, svx, svy, ux, uy, wx, wy, d, sn, tn, nx, ny;
    longint unsigned ud, ut, q, r, tm, mx, my, len;
    int n;
    logic found;
    tm = limit;
    found = 1'b0;
    nx = 0;
    ny = 0;
    px = longint'(ox) + ((longint'(offset_r) * longint'(vx)) >>> FRAC_BITS);
    py = longint'(oy) + ((longint'(offset_r) * longint'(vy)) >>> FRAC_BITS);
    svx = clamp31(longint'(vx));
    svy = clamp31(longint'(vy));
    n = (seg_count_r > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count_r);
    for (int i = 0; i < n; i++) begin
      ux = clamp31(longint'(segment_table[i].bx) - longint'(segment_table[i].ax));
      uy = clamp31(longint'(segment_table[i].by) - longint'(segment_table[i].ay));
      wx = clamp31(px - longint'(segment_table[i].ax));
      wy = clamp31(py - longint'(segment_table[i].ay));
      d  = svx * uy - svy * ux;
      sn = svx * wy - svy * wx;
      tn = ux * wy - uy * wx;
      if (d == 0) continue;
      if (d < 0) begin
        d = -d;
        sn = -sn;
        tn = -tn;
      end
      if (tn <= 0 || sn < 0 || sn > d) continue;
      ud = d;
      ut = tn;
      q = ut / ud;
      if (q >= 128) continue;
      r = ut % ud;
      repeat (FRAC_BITS) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 64'd1;
        end
      end
      // Strict compare: on a tie the lower slot stays the winner.
      if (q < tm) begin
        tm = q;
        found = 1'b1;
        mx = (ux < 0) ? -ux : ux;
        my = (uy < 0) ? -uy : uy;
        while ((mx | my) != 0 && mx < (64'd1 << 29) && my < (64'd1 << 29)) begin
          mx <<= 1;
          my <<= 1;
        end
        len = int_sqrt(mx * mx + my * my);
        nx = unit_comp(my, uy > 0, len);
        ny = unit_comp(mx, ux < 0, len);
      end
    end
    res.hx = clamp_coord(longint'(ox) + ((longint'(tm) * longint'(vx)) >>> FRAC_BITS));
    res.hy = clamp_coord(longint'(oy) + ((longint'(tm) * longint'(vy)) >>> FRAC_BITS));
    res.nx = found ? nx[31:0] : 32'sd0;
    res.ny = found ? ny[31:0] : 32'sd0;
    res.found = found;
    res.param = tm[30:0];
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    ray_result_t want;
    if (rst) begin
      seg_count_r <= 11'd0;
      offset_r    <= 16'd168;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEGMENT_COUNT) seg_count_r <= cfg_data[10:0];
        else offset_r <= cfg_data;
      end
      if (start && !busy) begin
        if (cmd == CMD_WRITE) begin
          segment_table[seg_index] = '{seg_ax, seg_ay, seg_bx, seg_by};
        end else begin
          hit_queue.push_back(nearest_hit(origin_x, origin_y, dir_x, dir_y, max_dist));
        end
      end
      if (done) begin
        if (hit_queue.size() == 0) begin
          report("unexpected result transfer", hit_param, 0);
        end else begin
          want = hit_queue.pop_front();
          if (hit_x !== want.hx) report("hit_x", hit_x, want.hx);
          if (hit_y !== want.hy) report("hit_y", hit_y, want.hy);
          if (normal_x !== want.nx) report("normal_x", normal_x, want.nx);
          if (normal_y !== want.ny) report("normal_y", normal_y, want.ny);
          if (hit_found !== want.found) report("hit_found", hit_found, want.found);
          if (hit_param !== want.param) report("hit_param", hit_param, want.param);
        end
      end
    end
    pending <= hit_queue.size();
  end

endmodule

### test/tb_ray_segment_nearest_hit.sv
// ----------------------------------------------------------------------------
// tb_ray_segment_nearest_hit
// Stimulus and verdict for the nearest-hit block. A directed part covers the
// geometric corner cases, then random phases with different idle rates and
// register settings follow. All checking happens in the checker instance
// beside the block.
// ----------------------------------------------------------------------------
module tb_ray_segment_nearest_hit;
  import rsnh_pkg::*;

  // One unit in Q8.24.
  localparam logic signed [31:0] ONE = 32'sh0100_0000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd = CMD_WRITE;
  logic [9:0]         seg_index = '0;
  logic signed [31:0] seg_ax = '0;
  logic signed [31:0] seg_ay = '0;
  logic signed [31:0] seg_bx = '0;
  logic signed [31:0] seg_by = '0;
  logic signed [31:0] origin_x = '0;
  logic signed [31:0] origin_y = '0;
  logic signed [31:0] dir_x = '0;
  logic signed [31:0] dir_y = '0;
  logic [30:0]        max_dist = '0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_SEGMENT_COUNT;
  logic [15:0]        cfg_data = '0;
  logic               done;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic               hit_found;
  logic [30:0]        hit_param;
  int                 fail_count;
  int                 pending;

  // Slots that have been written. A query only ever covers a prefix of the
  // table that is fully written, since reading an empty slot is undefined.
  logic seg_written[MAX_SEGMENTS];
  int   filled = 0;
  int   idle_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ray_segment_nearest_hit dut (.*);

  rsnh_checker checker_i (.*);

  // Hold start high until the block takes the transfer. Busy is read right
  // after the edge, so it still shows the value the edge sampled.
  task automatic transfer();
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Random sender gap before the next item, following the phase idle rate.
  task automatic sender_gap();
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_seg(input logic [9:0] idx, input logic signed [31:0] ax, ay, bx, by);
    cmd <= CMD_WRITE;
    seg_index <= idx;
    seg_ax <= ax;
    seg_ay <= ay;
    seg_bx <= bx;
    seg_by <= by;
    transfer();
    seg_written[idx] = 1'b1;
    while (filled < MAX_SEGMENTS && seg_written[filled]) filled++;
  endtask

  task automatic query(input logic signed [31:0] ox, oy, vx, vy, input logic [30:0] md);
    cmd <= CMD_QUERY;
    origin_x <= ox;
    origin_y <= oy;
    dir_x <= vx;
    dir_y <= vy;
    max_dist <= md;
    transfer();
  endtask

  // Wait until every query has answered, then leave room for the block to
  // settle before the registers change.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly coordinates within +-8.0 so rays meet segments; now and then any value.
  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
  endfunction

  function automatic logic signed [31:0] rand_dir();
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  function automatic logic [30:0] rand_limit();
    case ($urandom_range(9))
      7:       return 31'($urandom());
      8:       return 31'd0;
      9:       return 31'h7fff_ffff;
      default: return 31'($urandom_range(1, 32'h1000_0000));
    endcase
  endfunction

  // A random phase: about one item in four is a segment write into the low
  // part of the table, the rest are queries over the active prefix.
  task automatic random_phase(input int items);
    repeat (items) begin
      sender_gap();
      if (filled < 4 || $urandom_range(3) == 0) begin
        write_seg((filled < 40) ? 10'($urandom_range(0, filled)) : 10'($urandom_range(0, 39)),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else begin
        query(rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_limit());
      end
    end
  endtask

  initial begin
    foreach (seg_written[i]) seg_written[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: segment_count is still zero after reset.
    query('0, '0, ONE, '0, 31'h7fff_ffff);

    // Two vertical walls, a horizontal wall, a zero-length segment, a
    // full-range diagonal and a duplicate of the first wall for the tie.
    write_seg(10'd0, 2 * ONE, -ONE, 2 * ONE, ONE);
    write_seg(10'd1, 4 * ONE, -ONE, 4 * ONE, ONE);
    write_seg(10'd2, '0, 3 * ONE, 5 * ONE, 3 * ONE);
    write_seg(10'd3, ONE, 5 * ONE, ONE, 5 * ONE);
    write_seg(10'd4, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
    write_seg(10'd5, 2 * ONE, -ONE, 2 * ONE, ONE);
    drain();
    set_reg(CFG_SEGMENT_COUNT, 16'd6);

    query('0, -ONE / 2, ONE, '0, 31'h7fff_ffff);      // near wall wins over the tie copy
    query('0, '0, -ONE, '0, 31'h7fff_ffff);           // behind the origin
    query('0, -ONE / 2, ONE, '0, 31'd0);              // zero distance budget
    query(ONE / 2, '0, '0, ONE, 31'h7fff_ffff);       // parallel to one wall, hits another
    query(32'sh8100_0000, 32'sh0180_0000, ONE, '0, 31'h7fff_ffff); // beyond t = 128
    query(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff);
    query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff);
    query(3 * ONE, '0, -ONE, '0, 31'h0180_0000);      // wall just inside the budget

    // Random phases with varied idle rates and their own register settings.
    drain();
    set_reg(CFG_RAY_OFFSET, 16'd0);
    idle_pct = 0;
    random_phase(140);

    drain();
    set_reg(CFG_SEGMENT_COUNT, 16'(filled));
    set_reg(CFG_RAY_OFFSET, 16'hffff);
    idle_pct = 74;
    random_phase(140);

    drain();
    // Upper bits of the count register are not stored.
    set_reg(CFG_SEGMENT_COUNT, {5'h1f, 11'(filled)});
    set_reg(CFG_RAY_OFFSET, 16'd168);
    idle_pct = 0;
    random_phase(140);

    drain();
    set_reg(CFG_SEGMENT_COUNT, 16'($urandom_range(1, filled)));
    set_reg(CFG_RAY_OFFSET, 16'($urandom()));
    idle_pct = 19;
    random_phase(140);

    drain();
    if (fail_count == 0) begin
      $display("** ray_segment_nearest_hit: PASSED **");
    end else begin
      $display("** ray_segment_nearest_hit: FAILED **");
    end
    $finish;
  end

  // Watchdog well above the slowest legal run.
  initial begin
    #20_000_000;
    $display("** ray_segment_nearest_hit: FAILED **");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rsnh_pkg.sv
hw/rtl/rsnh_seg_mem.sv
hw/rtl/rsnh_div.sv
hw/rtl/rsnh_isqrt.sv
hw/rtl/ray_segment_nearest_hit.sv
test/rsnh_checker.sv
test/tb_ray_segment_nearest_hit.sv
